@@ rtl/bmm_pkg.sv @@
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared constants of the bipartite matching unit: field widths, register
// indexes and default sizes.
// ----------------------------------------------------------------------------
package bmm_pkg;

    // default store sizes
    localparam int DEF_MAX_LEFT  = 32;
    localparam int DEF_MAX_RIGHT = 32;

    // field widths
    localparam int IDX_W = 5;
    localparam int CNT_W = 6;
    localparam int REG_W = 1;

    // configuration register indexes
    typedef enum logic [REG_W-1:0] {
        REG_LEFT_COUNT  = 1'b0,
        REG_RIGHT_COUNT = 1'b1
    } t_reg_idx;

    // reset value of both count registers
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(32);

endpackage

@@ rtl/bmm_adj_store.sv @@
// ----------------------------------------------------------------------------
// bmm_adj_store
// Adjacency bit matrix: one row per left vertex, bit-masked edge writes,
// registered row read, per-row valid bits cleared at once.
// ----------------------------------------------------------------------------
module bmm_adj_store #(
    parameter int MAX_LEFT  = 32,
    parameter int MAX_RIGHT = 32,
    localparam int LW = $clog2(MAX_LEFT),
    localparam int RW = $clog2(MAX_RIGHT)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [LW-1:0]        i_wr_row,
    input  logic [RW-1:0]        i_wr_col,
    input  logic                 i_clr,
    input  logic                 i_rd_en,
    input  logic [LW-1:0]        i_rd_row,
    output logic [MAX_RIGHT-1:0] o_rd_data
);

    logic [MAX_RIGHT-1:0] mem [MAX_LEFT];
    logic [MAX_LEFT-1:0]  r_row_vld;
    logic [MAX_RIGHT-1:0] r_rd_q;
    logic                 r_rd_ok;
    logic [MAX_RIGHT-1:0] col_onehot;

    assign col_onehot = MAX_RIGHT'(1) << i_wr_col;

    // row valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_row] <= 1'b1;
        end
    end

    // edge write: set one bit, or start a fresh row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (r_row_vld[i_wr_row]) begin
                mem[i_wr_row][i_wr_col] <= 1'b1;
            end else begin
                mem[i_wr_row] <= col_onehot;
            end
        end
    end

    // registered row read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_q  <= mem[i_rd_row];
            r_rd_ok <= r_row_vld[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_q : '0;

endmodule

@@ rtl/bipartite_max_matching_unit.sv @@
// ----------------------------------------------------------------------------
// bipartite_max_matching_unit
// Loads graph edges into an adjacency matrix and, on the last item, counts
// a maximum matching by augmenting-path search with an explicit stack.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_stall  | left/right index, edge, last
//   out     | output    | o_out_valid / i_out_stall| matched_pairs
//   cfg     | input     | i_cfg_valid / o_cfg_ready| index, data
//
// Edge items are taken one per cycle while no search runs. A last item starts
// the search: a row fetch per left vertex, a scan step per right vertex, a step
// when a scan runs off its row, a partner check per hit, a step per pop and per
// frame on the walk back, a check that all roots are done, and the result post.
// Synchronous active-low reset; stores clear through valid bits.
// Input is stalled during the search; the result waits in an output register.
// ----------------------------------------------------------------------------
module bipartite_max_matching_unit
    import bmm_pkg::*;
#(
    parameter int MAX_LEFT  = DEF_MAX_LEFT,
    parameter int MAX_RIGHT = DEF_MAX_RIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [IDX_W-1:0] i_left_index,
    input  logic [IDX_W-1:0] i_right_index,
    input  logic             i_edge_valid,
    input  logic             i_last,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [CNT_W-1:0] o_matched_pairs,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [REG_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0] i_cfg_data
);

    localparam int LW  = $clog2(MAX_LEFT);
    localparam int RW  = $clog2(MAX_RIGHT);
    localparam int LCW = $clog2(MAX_LEFT + 1);
    localparam int RCW = $clog2(MAX_RIGHT + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ROOT, S_SCAN, S_PRD, S_UNWRD, S_POP, S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]     r_left_count, r_right_count;
    logic [LCW-1:0]       r_lc, r_u, r_total;
    logic [RCW-1:0]       r_rc, r_r;
    logic [LW-1:0]        r_cu, r_d;
    logic [MAX_RIGHT-1:0] r_vis;
    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_out_data;

    // partner of each right vertex
    logic [LW-1:0]        rp_mem [MAX_RIGHT];
    logic [MAX_RIGHT-1:0] r_rp_vld;
    logic [LW-1:0]        r_rp_q;
    logic                 r_rp_ok;

    // saved search frames
    logic [LW+RW-1:0]     stk_mem [MAX_LEFT];
    logic [LW+RW-1:0]     r_stk_q;
    logic [LW-1:0]        stk_left;
    logic [RW-1:0]        stk_right;

    logic                 in_acc, edge_wr;
    logic                 adj_rd_en, adj_clr;
    logic [LW-1:0]        adj_rd_row;
    logic [MAX_RIGHT-1:0] adj_row;
    logic [RW-1:0]        r_col;
    logic                 hit;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_matched_pairs = r_out_data;
    assign stk_left   = r_stk_q[LW+RW-1:RW];
    assign stk_right  = r_stk_q[RW-1:0];
    assign r_col      = r_r[RW-1:0];
    assign hit        = adj_row[r_col] && !r_vis[r_col];

    // edges beyond the store are dropped
    assign edge_wr = in_acc && i_edge_valid && (int'(i_left_index) < MAX_LEFT)
                     && (int'(i_right_index) < MAX_RIGHT);

    bmm_adj_store #(
        .MAX_LEFT (MAX_LEFT),
        .MAX_RIGHT(MAX_RIGHT)
    ) u_adj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (edge_wr),
        .i_wr_row (LW'(i_left_index)),
        .i_wr_col (RW'(i_right_index)),
        .i_clr    (adj_clr),
        .i_rd_en  (adj_rd_en),
        .i_rd_row (adj_rd_row),
        .o_rd_data(adj_row)
    );

    // row read and clear strobes and next state
    always_comb begin
        n_state    = r_state;
        adj_rd_en  = 1'b0;
        adj_rd_row = r_cu;
        adj_clr    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_last) n_state = S_ROOT;
            end
            S_ROOT: begin
                if (r_u == r_lc) begin
                    n_state = S_DONE;
                end else begin
                    adj_rd_en  = 1'b1;
                    adj_rd_row = r_u[LW-1:0];
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_r >= r_rc) begin
                    n_state = (r_d == '0) ? S_ROOT : S_POP;
                end else if (hit) begin
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                if (!r_rp_ok) begin
                    n_state = (r_d == '0) ? S_ROOT : S_UNWRD;
                end else begin
                    adj_rd_en  = 1'b1;
                    adj_rd_row = r_rp_q;
                    n_state    = S_SCAN;
                end
            end
            S_UNWRD: begin
                if (r_d == '0) n_state = S_ROOT;
            end
            S_POP: begin
                adj_rd_en  = 1'b1;
                adj_rd_row = stk_left;
                n_state    = S_SCAN;
            end
            S_DONE: begin
                if (!r_out_valid) begin
                    adj_clr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_left_count  <= COUNT_RESET;
            r_right_count <= COUNT_RESET;
            r_out_valid   <= 1'b0;
            r_rp_vld      <= '0;
            r_total       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_LEFT_COUNT:  r_left_count  <= i_cfg_data;
                    REG_RIGHT_COUNT: r_right_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_last) begin
                        r_lc <= (int'(r_left_count) > MAX_LEFT) ? LCW'(MAX_LEFT)
                                                                : LCW'(r_left_count);
                        r_rc <= (int'(r_right_count) > MAX_RIGHT) ? RCW'(MAX_RIGHT)
                                                                  : RCW'(r_right_count);
                        r_u     <= '0;
                        r_total <= '0;
                    end
                end
                S_ROOT: begin
                    r_vis <= '0;
                    r_d   <= '0;
                    r_cu  <= r_u[LW-1:0];
                    r_r   <= '0;
                end
                S_SCAN: begin
                    if (r_r >= r_rc) begin
                        if (r_d == '0) begin
                            r_u <= r_u + LCW'(1);
                        end else begin
                            r_d <= r_d - LW'(1);
                        end
                    end else if (hit) begin
                        r_vis[r_col] <= 1'b1;
                    end else begin
                        r_r <= r_r + RCW'(1);
                    end
                end
                S_PRD: begin
                    if (!r_rp_ok) begin
                        r_rp_vld[r_col] <= 1'b1;
                        if (r_d == '0) begin
                            r_total <= r_total + LCW'(1);
                            r_u     <= r_u + LCW'(1);
                        end else begin
                            r_d <= r_d - LW'(1);
                        end
                    end else begin
                        r_d  <= r_d + LW'(1);
                        r_cu <= r_rp_q;
                        r_r  <= '0;
                    end
                end
                S_UNWRD: begin
                    r_rp_vld[stk_right] <= 1'b1;
                    if (r_d == '0) begin
                        r_total <= r_total + LCW'(1);
                        r_u     <= r_u + LCW'(1);
                    end else begin
                        r_d <= r_d - LW'(1);
                    end
                end
                S_POP: begin
                    r_cu <= stk_left;
                    r_r  <= RCW'(stk_right) + RCW'(1);
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= CNT_W'(r_total);
                        r_rp_vld    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // partner store: write on augment, registered read on a hit
    always_ff @(posedge i_clk) begin
        if (r_state == S_PRD && !r_rp_ok) begin
            rp_mem[r_col] <= r_cu;
        end else if (r_state == S_UNWRD) begin
            rp_mem[stk_right] <= stk_left;
        end
        if (r_state == S_SCAN && r_r < r_rc && hit) begin
            r_rp_q  <= rp_mem[r_col];
            r_rp_ok <= r_rp_vld[r_col];
        end
    end

    // stack: push on a matched hit, read one frame below on pop or walk back
    always_ff @(posedge i_clk) begin
        if (r_state == S_PRD && r_rp_ok) begin
            stk_mem[r_d] <= {r_cu, r_col};
        end
        if ((r_state == S_SCAN && r_r >= r_rc && r_d != '0)
            || (r_state == S_PRD && !r_rp_ok && r_d != '0)
            || (r_state == S_UNWRD && r_d != '0)) begin
            r_stk_q <= stk_mem[r_d - LW'(1)];
        end
    end

`ifndef SYNTHESIS
    // scan position never passes the right count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_r <= r_rc))
        else $error("scan index beyond right count");

    // matches never exceed roots processed
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_total <= r_u))
        else $error("match total exceeds roots");

    // a last item starts the search
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last) |=> (r_state == S_ROOT))
        else $error("last item did not start search");

    // result is raised only from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside done");
`endif

endmodule

@@ test/bmm_checker.sv @@
// ----------------------------------------------------------------------------
// bmm_checker
// Watches the edge, result and register channels of the matching unit,
// keeps its own graph and register copy, predicts each matching size with a
// depth-first augmenting-path search and compares it with the block output.
// ----------------------------------------------------------------------------
module bmm_checker
    import bmm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [IDX_W-1:0] i_left_index,
    input  logic [IDX_W-1:0] i_right_index,
    input  logic             i_edge_valid,
    input  logic             i_last,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [CNT_W-1:0] i_matched_pairs,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [REG_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int NL = DEF_MAX_LEFT;
    localparam int NR = DEF_MAX_RIGHT;

    logic [NR-1:0]    graph_rows [NL];
    logic [CNT_W-1:0] left_cnt_q;
    logic [CNT_W-1:0] right_cnt_q;
    logic [CNT_W-1:0] size_queue [$];
    int               fail_total = 0;

    // per left vertex, depth-first search on an explicit stack over
    // free or re-routable right vertices, lowest index first
    function automatic logic [CNT_W-1:0] matching_size();
        int            owner [NR];
        int            st_left [NL];
        int            st_right [NL];
        int            st_next [NL];
        logic [NR-1:0] seen;
        int            lc;
        int            rc;
        int            total;
        int            d;
        int            r;
        bit            busy;
        bit            found;
        lc = (left_cnt_q > NL) ? NL : int'(left_cnt_q);
        rc = (right_cnt_q > NR) ? NR : int'(right_cnt_q);
        total = 0;
        foreach (owner[i]) owner[i] = -1;
        for (int u = 0; u < lc; u++) begin
            seen = '0;
            d = 0;
            st_left[0] = u;
            st_next[0] = 0;
            busy = 1'b1;
            found = 1'b0;
            while (busy) begin
                r = st_next[d];
                while (r < rc && !(graph_rows[st_left[d]][r] && !seen[r])) r++;
                if (r >= rc) begin
                    if (d == 0) busy = 1'b0;
                    else d--;
                end else begin
                    seen[r] = 1'b1;
                    st_next[d] = r + 1;
                    st_right[d] = r;
                    if (owner[r] < 0) begin
                        for (int k = 0; k <= d; k++) owner[st_right[k]] = st_left[k];
                        found = 1'b1;
                        busy = 1'b0;
                    end else begin
                        d++;
                        st_left[d] = owner[r];
                        st_next[d] = 0;
                    end
                end
            end
            if (found) total++;
        end
        return CNT_W'(total);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_total++;
    endtask

    assign o_fail_count = fail_total;
    assign o_pending = size_queue.size();

    // track registers, edges and results at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            left_cnt_q  <= COUNT_RESET;
            right_cnt_q <= COUNT_RESET;
            foreach (graph_rows[i]) graph_rows[i] = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_LEFT_COUNT) left_cnt_q <= i_cfg_data;
                else right_cnt_q <= i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (size_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d", i_matched_pairs));
                end else begin
                    if (i_matched_pairs !== size_queue[0])
                        report_mismatch($sformatf("matched_pairs %0d, expected %0d",
                                                  i_matched_pairs, size_queue[0]));
                    void'(size_queue.pop_front());
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_edge_valid) graph_rows[i_left_index][i_right_index] = 1'b1;
                if (i_last) begin
                    size_queue = {size_queue, matching_size()};
                    foreach (graph_rows[i]) graph_rows[i] = '0;
                end
            end
        end
    end

endmodule

@@ test/tb_bipartite_max_matching_unit.sv @@
// ----------------------------------------------------------------------------
// tb_bipartite_max_matching_unit
// Drives edge sets through the matching unit under several count settings,
// with random sender and receiver idling and a long receiver hold-off; a
// checker beside the block predicts and compares every matching size.
// ----------------------------------------------------------------------------
module tb_bipartite_max_matching_unit
    import bmm_pkg::*;
();

    localparam int CYCLE_LIMIT = 3000000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    logic             edge_valid;
    logic             last;
    logic             out_valid;
    logic             out_stall;
    logic [CNT_W-1:0] matched_pairs;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [REG_W-1:0] cfg_index;
    logic [CNT_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    int               send_idle_pct;
    int               recv_idle_pct;
    bit               hold_off;
    int               cycle_count = 0;

    bipartite_max_matching_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_left_index(left_index), .i_right_index(right_index),
        .i_edge_valid(edge_valid), .i_last(last),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_matched_pairs(matched_pairs),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    bmm_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_left_index(left_index), .i_right_index(right_index),
        .i_edge_valid(edge_valid), .i_last(last),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_matched_pairs(matched_pairs),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stall, redrawn every falling edge
    always @(negedge clk) begin
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // run guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver hold-off for a long stretch, counted in its own process
    task automatic hold_receiver(input int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(negedge clk);
        hold_off = 1'b0;
    endtask

    // offer one item and wait for its acceptance; valid stays up until the
    // next item, an idle cycle or an explicit drop replaces it
    task automatic send_item(input logic [IDX_W-1:0] l, input logic [IDX_W-1:0] r,
                             input logic e, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        left_index  <= l;
        right_index <= r;
        edge_valid  <= e;
        last        <= lst;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // wait until idle, then write one register
    task automatic write_count(input t_reg_idx idx, input logic [CNT_W-1:0] value);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one random graph: indexes over the full index range, some items without an edge
    task automatic send_graph(input int max_edges);
        int n;
        n = $urandom_range(max_edges);
        for (int i = 0; i < n; i++) begin
            send_item(5'($urandom), 5'($urandom), $urandom_range(9) != 0, 1'b0);
        end
        send_item(5'($urandom), 5'($urandom), 1'($urandom), 1'b1);
    endtask

    task automatic random_phase(input int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            send_graph(24);
            sent += 13;
        end
    endtask

    initial begin
        rst_n = 1'b0; in_valid = 1'b0; left_index = '0; right_index = '0;
        edge_valid = 1'b0; last = 1'b0; cfg_valid = 1'b0; cfg_index = REG_LEFT_COUNT;
        cfg_data = '0; hold_off = 1'b0;
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed: corners, duplicate, edge-less last, part of a row and a column, count settings
        send_item(5'd0, 5'd0, 1'b1, 1'b0);
        send_item(5'd0, 5'd0, 1'b1, 1'b0);
        send_item(5'd31, 5'd31, 1'b1, 1'b0);
        send_item(5'd3, 5'd7, 1'b0, 1'b1);
        for (int i = 0; i < 8; i++) send_item(5'd0, 5'(i), 1'b1, 1'b0);
        for (int i = 1; i < 4; i++) send_item(5'(i), 5'd0, 1'b1, 1'b0);
        send_item(5'd1, 5'd1, 1'b1, 1'b1);
        send_item(5'd2, 5'd5, 1'b1, 1'b1);
        write_count(REG_LEFT_COUNT, 6'd0);
        send_item(5'd0, 5'd0, 1'b1, 1'b1);
        write_count(REG_LEFT_COUNT, 6'd63);
        write_count(REG_RIGHT_COUNT, 6'd1);
        send_item(5'd4, 5'd0, 1'b1, 1'b0);
        send_item(5'd9, 5'd0, 1'b1, 1'b0);
        send_item(5'd9, 5'd20, 1'b1, 1'b1);
        write_count(REG_RIGHT_COUNT, 6'd0);
        send_item(5'd0, 5'd0, 1'b1, 1'b1);
        write_count(REG_RIGHT_COUNT, 6'd32);
        // long chain forcing deep search stacks
        for (int i = 0; i < 32; i++) begin
            send_item(5'(i), 5'(i), 1'b1, 1'b0);
            if (i < 31) send_item(5'(i + 1), 5'(i), 1'b1, 1'b0);
        end
        send_item(5'd0, 5'd31, 1'b0, 1'b1);

        // random phases under changing idling and counts
        send_idle_pct = 31; recv_idle_pct = 67;
        random_phase(300);
        write_count(REG_LEFT_COUNT, 6'($urandom_range(1, 32)));
        write_count(REG_RIGHT_COUNT, 6'($urandom_range(1, 32)));
        send_idle_pct = 67; recv_idle_pct = 31;
        random_phase(300);
        write_count(REG_LEFT_COUNT, 6'd8);
        write_count(REG_RIGHT_COUNT, 6'd40);
        send_idle_pct = 0; recv_idle_pct = 0;
        fork
            hold_receiver(3000);
            begin
                for (int i = 0; i < 20; i++) send_item(5'(i), 5'(i), 1'b1, 1'b1);
            end
        join
        random_phase(250);
        write_count(REG_LEFT_COUNT, 6'd32);
        write_count(REG_RIGHT_COUNT, 6'd32);
        random_phase(400);

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ bipartite_max_matching_unit.f @@
rtl/bmm_pkg.sv
rtl/bmm_adj_store.sv
rtl/bipartite_max_matching_unit.sv
test/bmm_checker.sv
test/tb_bipartite_max_matching_unit.sv
